// ===== hdl/fridge_sensor_ook_frame_decoder_top_defines.svh =====
// Assertion macros for the frame decoder.
`ifndef FRIDGE_SENSOR_OOK_FRAME_DECODER_TOP_DEFINES_SVH
`define FRIDGE_SENSOR_OOK_FRAME_DECODER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FSOFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FSOFD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSOFD_ASSERT(lbl, prop, msg)
`define FSOFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/fsofd_pkg.sv =====
package fsofd_pkg;

	localparam int FRAME_BITS     = 40;
	localparam int CHECKED_BITS   = 32;
	localparam int FRAME_PULSES   = 2 * FRAME_BITS;
	localparam int CHECKED_PULSES = 2 * CHECKED_BITS;
	localparam int FIFO_DEPTH     = 2;
	localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
	localparam int FIFO_LW        = $clog2(FIFO_DEPTH + 1);

	localparam logic [15:0] RST_LONG_GAP   = 16'd2000;
	localparam logic [15:0] RST_ONE_THRESH = 16'd650;
	localparam logic [7:0]  RST_MIN_PULSES = 8'd84;
	localparam logic [7:0]  RST_MAX_PULSES = 8'd88;

	localparam logic [1:0] REG_LONG_GAP   = 2'd0;
	localparam logic [1:0] REG_ONE_THRESH = 2'd1;
	localparam logic [1:0] REG_MIN_PULSES = 2'd2;
	localparam logic [1:0] REG_MAX_PULSES = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_CNT  = 3'd1;
	localparam logic [2:0] ST_LONG_GAP = 3'd2;
	localparam logic [2:0] ST_ZERO     = 3'd3;
	localparam logic [2:0] ST_CRC      = 3'd4;

	localparam logic [7:0]  CNT_MAX     = 8'hFF;
	localparam logic [7:0]  CRC_POLY    = 8'h07;
	localparam logic [8:0]  F_OFFSET    = 9'd32;
	// floor(m * 7282 / 2^16) equals m / 9 for m up to 795
	localparam logic [12:0] DIV9_RECIP  = 13'd7282;

	function automatic logic [7:0] flip8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7 - i];
		end
		return r;
	endfunction

	localparam logic [7:0] CRC_POLY_REFL = flip8(CRC_POLY);

	typedef struct packed {
		logic [15:0] long_gap_limit;
		logic [15:0] one_threshold;
		logic [7:0]  min_pulses;
		logic [7:0]  max_pulses;
	} cfg_regs_t;

	typedef struct packed {
		logic [7:0]              pulse_count;
		logic [FRAME_BITS-1:0]   bits;
		logic                    long_gap;
		logic [7:0]              crc_rem;
	} frame_rec_t;

endpackage

// ===== hdl/fsofd_pulse_if.sv =====
interface fsofd_pulse_if;
	import fsofd_pkg::*;
	logic        valid;
	logic        ready;
	logic [15:0] pulse_length;
	logic        frame_end;

	modport source (output valid, output pulse_length, output frame_end, input ready);
	modport sink (input valid, input pulse_length, input frame_end, output ready);
endinterface

// ===== hdl/fsofd_result_if.sv =====
interface fsofd_result_if;
	import fsofd_pkg::*;
	logic               valid;
	logic               ready;
	logic [2:0]         frame_status;
	logic [15:0]        sensor_id;
	logic [1:0]         unit_number;
	logic               battery_ok;
	logic signed [10:0] celsius_tenths;

	modport source (output valid, output frame_status, output sensor_id, output unit_number,
		output battery_ok, output celsius_tenths, input ready);
	modport sink (input valid, input frame_status, input sensor_id, input unit_number,
		input battery_ok, input celsius_tenths, output ready);
endinterface

// ===== hdl/fsofd_cfg_if.sv =====
interface fsofd_cfg_if;
	import fsofd_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fsofd_front.sv =====
module fsofd_front
	import fsofd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	fsofd_pulse_if.sink   pulse,
	input  cfg_regs_t     cfg_regs,
	input  logic          full,
	output logic          push,
	output frame_rec_t    rec
);

	logic [7:0]            cnt_q, cnt_nx;
	logic [FRAME_BITS-1:0] shift_q, shift_nx;
	logic                  lg_q, lg_nx;
	logic [7:0]            crc_q, crc_nx, crc_step;
	logic                  acc, take_bit, checked, bit_in, fb;

	assign pulse.ready = !full;
	assign acc         = pulse.valid && pulse.ready;

	always_comb begin
		cnt_nx   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 8'd1;
		take_bit = cnt_nx[0] && (cnt_nx < 8'(FRAME_PULSES));
		checked  = take_bit && (cnt_nx < 8'(CHECKED_PULSES));
		bit_in   = pulse.pulse_length > cfg_regs.one_threshold;
		shift_nx = take_bit ? {shift_q[FRAME_BITS-2:0], bit_in} : shift_q;
		lg_nx    = lg_q || (checked && (pulse.pulse_length > cfg_regs.long_gap_limit));
		// serial reflected CRC, bits arrive LSB first per byte
		fb       = crc_q[0] ^ bit_in;
		crc_step = {1'b0, crc_q[7:1]} ^ (fb ? CRC_POLY_REFL : 8'h00);
		crc_nx   = checked ? crc_step : crc_q;
	end

	assign push = acc && pulse.frame_end;
	assign rec  = '{pulse_count: cnt_nx, bits: shift_nx, long_gap: lg_nx, crc_rem: crc_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			shift_q <= '0;
			lg_q    <= 1'b0;
			crc_q   <= '0;
		end else if (acc) begin
			if (pulse.frame_end) begin
				cnt_q   <= '0;
				shift_q <= '0;
				lg_q    <= 1'b0;
				crc_q   <= '0;
			end else begin
				cnt_q   <= cnt_nx;
				shift_q <= shift_nx;
				lg_q    <= lg_nx;
				crc_q   <= crc_nx;
			end
		end
	end

endmodule

// ===== hdl/fsofd_fifo.sv =====
module fsofd_fifo
	import fsofd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  frame_rec_t         wr_rec,
	input  logic               pop,
	output frame_rec_t         rd_rec,
	output logic               full,
	output logic               rd_valid,
	output logic [FIFO_LW-1:0] level
);

	frame_rec_t         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_LW-1:0] level_q;

	assign full     = (level_q == FIFO_LW'(FIFO_DEPTH));
	assign rd_valid = (level_q != '0);
	assign rd_rec   = mem_q[rd_ptr_q];
	assign level    = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/fsofd_back.sv =====
module fsofd_back
	import fsofd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_regs_t       cfg_regs,
	input  logic            rd_valid,
	input  frame_rec_t      rd_rec,
	output logic            pop,
	fsofd_result_if.source  result
);

	logic [7:0]         d0, d1, d2, d3, crc_rx;
	logic [2:0]         status;
	logic signed [8:0]  f_val, t_val;
	logic signed [10:0] t_ext, m5, m5_abs;
	logic               ok;

	logic               v_s1;
	logic [2:0]         status_s1;
	logic [15:0]        id_s1;
	logic [1:0]         unit_s1;
	logic               bat_s1;
	logic [9:0]         mag_s1;
	logic               neg_s1;

	logic               out_v_q;
	logic [2:0]         status_q;
	logic [15:0]        id_q;
	logic [1:0]         unit_q;
	logic               bat_q;
	logic signed [10:0] tenths_q;

	logic               adv2;
	logic [22:0]        prod;
	logic [6:0]         quo;
	logic [9:0]         ten_mag;
	logic signed [10:0] tenths_nx;

	always_comb begin
		d0     = flip8(rd_rec.bits[39:32]);
		d1     = flip8(rd_rec.bits[31:24]);
		d2     = flip8(rd_rec.bits[23:16]);
		d3     = flip8(rd_rec.bits[15:8]);
		crc_rx = flip8(rd_rec.bits[7:0]);
		if (rd_rec.pulse_count < 8'(FRAME_PULSES) ||
			rd_rec.pulse_count < cfg_regs.min_pulses ||
			rd_rec.pulse_count > cfg_regs.max_pulses) begin
			status = ST_BAD_CNT;
		end else if (rd_rec.long_gap) begin
			status = ST_LONG_GAP;
		end else if (rd_rec.bits[39:8] == 32'd0) begin
			status = ST_ZERO;
		end else if (rd_rec.crc_rem != crc_rx) begin
			status = ST_CRC;
		end else begin
			status = ST_OK;
		end
		ok     = (status == ST_OK);
		f_val  = d0[7] ? -$signed({2'b00, d0[6:0]}) : $signed({2'b00, d0[6:0]});
		t_val  = f_val - $signed(F_OFFSET);
		t_ext  = {{2{t_val[8]}}, t_val};
		m5     = (t_ext <<< 2) + t_ext;
		m5_abs = m5[10] ? -m5 : m5;
	end

	assign adv2 = !out_v_q || result.ready;
	assign pop  = rd_valid && (!v_s1 || adv2);

	always_ff @(posedge clk) begin
		if (pop) begin
			status_s1 <= status;
			id_s1     <= ok ? {d1, d2} : 16'd0;
			unit_s1   <= ok ? {1'b0, d3[0]} + 2'd1 : 2'd0;
			bat_s1    <= ok && !d3[1];
			mag_s1    <= ok ? m5_abs[9:0] : 10'd0;
			neg_s1    <= ok && m5[10];
		end
	end

	always_comb begin
		prod      = 23'(mag_s1) * 23'(DIV9_RECIP);
		quo       = prod[22:16];
		ten_mag   = 10'({quo, 3'b000}) + 10'({quo, 1'b0});
		tenths_nx = neg_s1 ? -$signed({1'b0, ten_mag}) : $signed({1'b0, ten_mag});
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			status_q <= status_s1;
			id_q     <= id_s1;
			unit_q   <= unit_s1;
			bat_q    <= bat_s1;
			tenths_q <= tenths_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (adv2) begin
				v_s1 <= 1'b0;
			end
			if (adv2) begin
				out_v_q <= v_s1;
			end
		end
	end

	assign result.valid          = out_v_q;
	assign result.frame_status   = status_q;
	assign result.sensor_id      = id_q;
	assign result.unit_number    = unit_q;
	assign result.battery_ok     = bat_q;
	assign result.celsius_tenths = tenths_q;

endmodule

// ===== hdl/fridge_sensor_ook_frame_decoder_top.sv =====
// Channel  | Dir | Payload                                   | Accepted when
// pulse    | in  | pulse_length, frame_end                   | valid && ready
// result   | out | frame_status, sensor_id, unit_number,     | valid && ready
//          |     | battery_ok, celsius_tenths                |
// cfg      | in  | index, data                               | valid && ready
//
// One pulse per cycle while not full; bits and CRC are built serially as gaps arrive.
// After its end beat, a frame result passes the queue, decode stage, then output reg.
// Two-entry frame queue between front and back; pulse.ready drops only when it is full.
// arst_n clears counters, shift state, queue and valids; config regs return to defaults.
// cfg.ready is always high.
`include "fridge_sensor_ook_frame_decoder_top_defines.svh"
module fridge_sensor_ook_frame_decoder_top
	import fsofd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	fsofd_pulse_if.sink    pulse,
	fsofd_result_if.source result,
	fsofd_cfg_if.sink      cfg
);

	cfg_regs_t          cfg_regs_q;
	frame_rec_t         wr_rec, rd_rec;
	logic               push, pop, full, rd_valid;
	logic [FIFO_LW-1:0] fifo_level;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q <= '{long_gap_limit: RST_LONG_GAP, one_threshold: RST_ONE_THRESH,
				min_pulses: RST_MIN_PULSES, max_pulses: RST_MAX_PULSES};
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_LONG_GAP:   cfg_regs_q.long_gap_limit <= cfg.data;
				REG_ONE_THRESH: cfg_regs_q.one_threshold  <= cfg.data;
				REG_MIN_PULSES: cfg_regs_q.min_pulses     <= cfg.data[7:0];
				REG_MAX_PULSES: cfg_regs_q.max_pulses     <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	fsofd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pulse    (pulse),
		.cfg_regs (cfg_regs_q),
		.full     (full),
		.push     (push),
		.rec      (wr_rec)
	);

	fsofd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_rec   (wr_rec),
		.pop      (pop),
		.rd_rec   (rd_rec),
		.full     (full),
		.rd_valid (rd_valid),
		.level    (fifo_level)
	);

	fsofd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs_q),
		.rd_valid (rd_valid),
		.rd_rec   (rd_rec),
		.pop      (pop),
		.result   (result)
	);

	`FSOFD_ASSERT(a_fifo_bound, fifo_level <= FIFO_LW'(FIFO_DEPTH), "queue level overflow")
	`FSOFD_ASSERT(a_end_queued, pulse.valid && pulse.ready && pulse.frame_end |=> fifo_level != '0, "frame end beat not queued")
	`FSOFD_ASSERT(a_reject_zero, result.valid && result.frame_status != ST_OK |-> result.sensor_id == 16'd0 && result.unit_number == 2'd0 && !result.battery_ok && result.celsius_tenths == 11'sd0, "rejected frame carries data")
	`FSOFD_ASSERT(a_ok_unit, result.valid && result.frame_status == ST_OK |-> result.unit_number != 2'd0, "good frame without unit")

endmodule
